### hw/rtl/l2lpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l2lpc_pkg
// Encodings and word types shared by the L2 line protocol controller.
// ----------------------------------------------------------------------------
package l2lpc_pkg;

    // command codes
    localparam logic [2:0] CMD_REPLACE = 3'd0;
    localparam logic [2:0] CMD_IREAD   = 3'd1;
    localparam logic [2:0] CMD_DREAD   = 3'd2;
    localparam logic [2:0] CMD_DWRITE  = 3'd3;
    localparam logic [2:0] CMD_FILL    = 3'd4;
    localparam logic [2:0] CMD_FLUSH   = 3'd5;

    // line states
    localparam logic [2:0] ST_NOT_PRESENT = 3'd0;
    localparam logic [2:0] ST_INVALID     = 3'd1;
    localparam logic [2:0] ST_READ_PEND   = 3'd2;
    localparam logic [2:0] ST_WRITE_PEND  = 3'd3;
    localparam logic [2:0] ST_CLEAN       = 3'd4;
    localparam logic [2:0] ST_DIRTY       = 3'd5;

    // stall codes
    localparam logic [1:0] STALL_NONE   = 2'd0;
    localparam logic [1:0] STALL_POLL   = 2'd1;
    localparam logic [1:0] STALL_EVENT  = 2'd2;
    localparam logic [1:0] STALL_INSERT = 2'd3;

    // data store kinds
    localparam logic [1:0] STORE_NONE      = 2'd0;
    localparam logic [1:0] STORE_WRITE     = 2'd1;
    localparam logic [1:0] STORE_WRITE_VAL = 2'd2;
    localparam logic [1:0] STORE_FILL      = 2'd3;

    // requests toward memory
    localparam logic [1:0] DOWN_NONE      = 2'd0;
    localparam logic [1:0] DOWN_READ      = 2'd1;
    localparam logic [1:0] DOWN_WRITEBACK = 2'd2;

    // hit response targets, also the inclusion bit of each requester
    localparam logic [1:0] RESP_NONE   = 2'd0;
    localparam logic [1:0] RESP_ICACHE = 2'd1;
    localparam logic [1:0] RESP_DCACHE = 2'd2;

    typedef struct packed {
        logic [2:0] command;
        logic [2:0] line_state;
        logic [1:0] inclusion_in;
        logic       can_insert;
        logic       mshr_free;
        logic       mshr_queue_space;
    } l2lpc_req_t;

    typedef struct packed {
        logic [2:0] new_state;
        logic [1:0] stall_code;
        logic       protocol_error;
        logic       insert_line;
        logic       mshr_allocate;
        logic       mshr_enqueue;
        logic       mshr_complete;
        logic [1:0] data_store;
        logic [1:0] send_down;
        logic [1:0] respond_to;
        logic [1:0] invalidate_mask;
        logic [1:0] inclusion_out;
    } l2lpc_rsp_t;

endpackage
`default_nettype wire

### hw/rtl/l2lpc_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l2lpc_decode
// Transition table of one L2 line: next state, stall, error and action strobes.
// ----------------------------------------------------------------------------
module l2lpc_decode
    import l2lpc_pkg::*;
(
    input  l2lpc_req_t req,
    output l2lpc_rsp_t rsp
);

    logic       rd;
    logic [1:0] rbit;
    logic [1:0] incl;

    assign rd   = (req.command == CMD_IREAD) || (req.command == CMD_DREAD);
    assign rbit = (req.command == CMD_IREAD) ? RESP_ICACHE : RESP_DCACHE;

    always_comb
    begin
        rsp                 = '0;
        rsp.new_state       = req.line_state;
        rsp.stall_code      = STALL_NONE;
        rsp.data_store      = STORE_NONE;
        rsp.send_down       = DOWN_NONE;
        rsp.respond_to      = RESP_NONE;
        rsp.inclusion_out   = req.inclusion_in;
        incl                = req.inclusion_in;

        if (req.line_state > ST_DIRTY || req.command > CMD_FILL)
        begin
            rsp.protocol_error = 1'b1;
        end
        else
        begin
            case (req.line_state)
                ST_NOT_PRESENT, ST_INVALID:
                begin
                    if (req.command == CMD_REPLACE)
                    begin
                        // nothing to drop
                    end
                    else if (req.command == CMD_FILL)
                    begin
                        rsp.protocol_error = 1'b1;
                    end
                    else if (req.line_state == ST_NOT_PRESENT && !req.can_insert)
                    begin
                        rsp.stall_code = STALL_INSERT;
                    end
                    else if (!req.mshr_free)
                    begin
                        rsp.stall_code = STALL_EVENT;
                    end
                    else if (rd && !req.mshr_queue_space)
                    begin
                        rsp.stall_code = STALL_POLL;
                    end
                    else
                    begin
                        // fresh frame starts with no inclusion bits
                        if (req.line_state == ST_NOT_PRESENT)
                        begin
                            rsp.insert_line = 1'b1;
                            incl            = 2'b00;
                        end
                        rsp.mshr_allocate = 1'b1;
                        rsp.send_down     = DOWN_READ;
                        if (rd)
                        begin
                            rsp.mshr_enqueue  = 1'b1;
                            rsp.inclusion_out = incl | rbit;
                            rsp.new_state     = ST_READ_PEND;
                        end
                        else
                        begin
                            rsp.data_store    = STORE_WRITE_VAL;
                            rsp.inclusion_out = incl;
                            rsp.new_state     = ST_WRITE_PEND;
                        end
                    end
                end
                ST_READ_PEND, ST_WRITE_PEND:
                begin
                    if (rd)
                    begin
                        if (!req.mshr_queue_space)
                        begin
                            rsp.stall_code = STALL_POLL;
                        end
                        else
                        begin
                            rsp.mshr_enqueue  = 1'b1;
                            rsp.inclusion_out = req.inclusion_in | rbit;
                        end
                    end
                    else if (req.command == CMD_DWRITE)
                    begin
                        rsp.data_store = STORE_WRITE_VAL;
                        rsp.new_state  = ST_WRITE_PEND;
                    end
                    else if (req.command == CMD_FILL)
                    begin
                        rsp.data_store    = STORE_FILL;
                        rsp.mshr_complete = 1'b1;
                        rsp.new_state     = (req.line_state == ST_READ_PEND) ?
                                            ST_CLEAN : ST_DIRTY;
                    end
                    else
                    begin
                        // replace must wait for the fill
                        rsp.stall_code = STALL_EVENT;
                    end
                end
                default:
                begin
                    // clean or dirty
                    if (rd)
                    begin
                        rsp.respond_to    = rbit;
                        rsp.inclusion_out = req.inclusion_in | rbit;
                    end
                    else if (req.command == CMD_DWRITE)
                    begin
                        rsp.data_store      = STORE_WRITE;
                        rsp.invalidate_mask = req.inclusion_in & RESP_ICACHE;
                        rsp.new_state       = ST_DIRTY;
                    end
                    else if (req.command == CMD_FILL)
                    begin
                        rsp.protocol_error = 1'b1;
                    end
                    else
                    begin
                        rsp.invalidate_mask = req.inclusion_in;
                        rsp.inclusion_out   = 2'b00;
                        if (req.line_state == ST_DIRTY)
                        begin
                            rsp.send_down = DOWN_WRITEBACK;
                        end
                        rsp.new_state = ST_INVALID;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### hw/rtl/l2_line_protocol_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// l2_line_protocol_controller
// Per-line state transition of a writeback L2 with icache/dcache inclusion.
// ----------------------------------------------------------------------------
// Timing: a word taken into the input register passes the decode table into the
// result register and shows on the result ports with done high; one word is taken every cycle.
// The path is input register, decode table, result register; busy stays low.
// The receiver cannot stall: each result is on the ports for one cycle only.
// Reset (rst_n low, asynchronous) drops all words in flight; no result follows.
module l2_line_protocol_controller
    import l2lpc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] command,
    input  wire logic [2:0] line_state,
    input  wire logic [1:0] inclusion_in,
    input  wire logic       can_insert,
    input  wire logic       mshr_free,
    input  wire logic       mshr_queue_space,
    output logic            done,
    output logic [2:0]      new_state,
    output logic [1:0]      stall_code,
    output logic            protocol_error,
    output logic            insert_line,
    output logic            mshr_allocate,
    output logic            mshr_enqueue,
    output logic            mshr_complete,
    output logic [1:0]      data_store,
    output logic [1:0]      send_down,
    output logic [1:0]      respond_to,
    output logic [1:0]      invalidate_mask,
    output logic [1:0]      inclusion_out
);

    l2lpc_req_t req_reg;
    logic       req_valid_reg;
    l2lpc_rsp_t rsp_next;
    l2lpc_rsp_t rsp_reg;
    logic       rsp_valid_reg;
    logic       accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= accept;
            rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.command          <= command;
            req_reg.line_state       <= line_state;
            req_reg.inclusion_in     <= inclusion_in;
            req_reg.can_insert       <= can_insert;
            req_reg.mshr_free        <= mshr_free;
            req_reg.mshr_queue_space <= mshr_queue_space;
        end
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    l2lpc_decode u_decode
    (
        .req (req_reg),
        .rsp (rsp_next)
    );

    assign done            = rsp_valid_reg;
    assign new_state       = rsp_reg.new_state;
    assign stall_code      = rsp_reg.stall_code;
    assign protocol_error  = rsp_reg.protocol_error;
    assign insert_line     = rsp_reg.insert_line;
    assign mshr_allocate   = rsp_reg.mshr_allocate;
    assign mshr_enqueue    = rsp_reg.mshr_enqueue;
    assign mshr_complete   = rsp_reg.mshr_complete;
    assign data_store      = rsp_reg.data_store;
    assign send_down       = rsp_reg.send_down;
    assign respond_to      = rsp_reg.respond_to;
    assign invalidate_mask = rsp_reg.invalidate_mask;
    assign inclusion_out   = rsp_reg.inclusion_out;

    // a result only follows a word taken through the input and result registers
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result without a word taken");

    // a stall keeps the line where it was
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (done && stall_code != STALL_NONE) |-> new_state == $past(line_state, 2))
        else $error("stall changed the line state");

    // a protocol error (illegal command or state) fires no action
    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && protocol_error) |-> (!insert_line && !mshr_allocate &&
        !mshr_enqueue && !mshr_complete && stall_code == STALL_NONE &&
        data_store == STORE_NONE && send_down == DOWN_NONE))
        else $error("action strobe on protocol error");

    // a fresh frame holds at most the requester's inclusion bit
    a_insert_incl: assert property (@(posedge clk) disable iff (!rst_n)
        (done && insert_line) |-> $countones(inclusion_out) <= 1)
        else $error("stale inclusion bits on insert");

endmodule
`default_nettype wire
